// ===== design/hpr2_pkg.sv =====
// Shared types and constants for the Hermitian packed rank-2 update core.
// No dependencies; used by every module of the core.
package hpr2_pkg;

    localparam int unsigned MAX_ORDER = 1024;

    localparam int unsigned POS_W   = 10;
    localparam int unsigned ORDER_W = 11;
    localparam int unsigned IDX_W   = 20;
    localparam int unsigned VEC_W   = 16;
    localparam int unsigned ELEM_W  = 32;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    typedef enum logic [1:0] {
        REG_ALPHA_RE   = 2'd0,
        REG_ALPHA_IM   = 2'd1,
        REG_UPPER_MODE = 2'd2,
        REG_ORDER      = 2'd3
    } t_reg_sel;

    typedef struct packed {
        logic signed [VEC_W-1:0] alpha_re;
        logic signed [VEC_W-1:0] alpha_im;
        logic                    upper_mode;
        logic [ORDER_W-1:0]      order;
    } t_cfg;

    // Per-item control that follows the datapath
    typedef struct packed {
        logic             in_tri;
        logic             diag;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

// ===== design/hpr2_regs.sv =====
// APB configuration registers: alpha, triangle mode and matrix order.
// Depends on hpr2_pkg.
module hpr2_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hpr2_pkg::ADDR_W-1:0]  paddr,
    input  logic [hpr2_pkg::DATA_W-1:0]  pwdata,
    output logic [hpr2_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output hpr2_pkg::t_cfg               o_cfg
);

    hpr2_pkg::t_cfg   r_cfg;
    hpr2_pkg::t_cfg   n_cfg;
    hpr2_pkg::t_reg_sel w_sel;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_sel  = hpr2_pkg::t_reg_sel'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_sel)
                hpr2_pkg::REG_ALPHA_RE:   n_cfg.alpha_re   = pwdata[hpr2_pkg::VEC_W-1:0];
                hpr2_pkg::REG_ALPHA_IM:   n_cfg.alpha_im   = pwdata[hpr2_pkg::VEC_W-1:0];
                hpr2_pkg::REG_UPPER_MODE: n_cfg.upper_mode = pwdata[0];
                hpr2_pkg::REG_ORDER:      n_cfg.order      = pwdata[hpr2_pkg::ORDER_W-1:0];
                default:                  n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha_re   <= '0;
            r_cfg.alpha_im   <= '0;
            r_cfg.upper_mode <= 1'b1;
            r_cfg.order      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_sel)
            hpr2_pkg::REG_ALPHA_RE:   prdata = hpr2_pkg::DATA_W'(r_cfg.alpha_re);
            hpr2_pkg::REG_ALPHA_IM:   prdata = hpr2_pkg::DATA_W'(r_cfg.alpha_im);
            hpr2_pkg::REG_UPPER_MODE: prdata = hpr2_pkg::DATA_W'(r_cfg.upper_mode);
            hpr2_pkg::REG_ORDER:      prdata = hpr2_pkg::DATA_W'(r_cfg.order);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/hpr2_index.sv =====
// Triangle test and packed index, one registered stage.
// Depends on hpr2_pkg.
module hpr2_index #(
    parameter int unsigned MAX_ORDER = hpr2_pkg::MAX_ORDER
) (
    input  logic                        i_clk,
    input  hpr2_pkg::t_cfg              i_cfg,
    input  logic [hpr2_pkg::POS_W-1:0]  i_col_pos,
    input  logic [hpr2_pkg::POS_W-1:0]  i_row_pos,
    output hpr2_pkg::t_tag              o_tag
);

    localparam int unsigned MB_W   = hpr2_pkg::ORDER_W + 2;
    localparam int unsigned PROD_W = hpr2_pkg::POS_W + MB_W;

    logic [hpr2_pkg::ORDER_W-1:0] w_n;
    logic                         w_in_tri;
    logic [hpr2_pkg::POS_W-1:0]   w_offset;
    logic [MB_W-1:0]              w_mul_b;
    logic [PROD_W-1:0]            w_prod;
    logic [PROD_W-2:0]            w_sum;
    hpr2_pkg::t_tag               r_tag;
    hpr2_pkg::t_tag               n_tag;

    always_comb begin
        w_n = (32'(i_cfg.order) > 32'(MAX_ORDER)) ? hpr2_pkg::ORDER_W'(MAX_ORDER)
                                                  : i_cfg.order;
        if (i_cfg.upper_mode) begin
            w_in_tri = (hpr2_pkg::ORDER_W'(i_row_pos) < w_n) && (i_col_pos <= i_row_pos);
            w_mul_b  = MB_W'(i_row_pos) + MB_W'(1);
            w_offset = i_col_pos;
        end else begin
            w_in_tri = (hpr2_pkg::ORDER_W'(i_col_pos) < w_n) && (i_row_pos <= i_col_pos);
            w_mul_b  = {1'b0, w_n, 1'b0} - MB_W'(i_row_pos) + MB_W'(1);
            w_offset = i_col_pos - i_row_pos;
        end
        w_prod = PROD_W'(i_row_pos) * PROD_W'(w_mul_b);
        w_sum  = w_prod[PROD_W-1:1] + (PROD_W-1)'(w_offset);

        n_tag.in_tri = w_in_tri;
        n_tag.diag   = (i_col_pos == i_row_pos);
        n_tag.idx    = w_in_tri ? w_sum[hpr2_pkg::IDX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    assign o_tag = r_tag;

endmodule

// ===== design/hpr2_mac.sv =====
// Complex multiply-accumulate pipeline: products, sums, alpha scaling,
// truncation and saturating add. Depends on hpr2_pkg.
module hpr2_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hpr2_pkg::t_cfg                     i_cfg,
    input  logic                               i_vld,
    input  logic signed [hpr2_pkg::VEC_W-1:0]  i_x_col_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]  i_x_col_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]  i_y_col_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]  i_y_col_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]  i_x_row_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]  i_x_row_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]  i_y_row_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]  i_y_row_im,
    input  logic signed [hpr2_pkg::ELEM_W-1:0] i_ap_re,
    input  logic signed [hpr2_pkg::ELEM_W-1:0] i_ap_im,
    input  hpr2_pkg::t_tag                     i_s1_tag,
    output logic                               o_valid,
    output logic [hpr2_pkg::IDX_W-1:0]         o_packed_index,
    output logic signed [hpr2_pkg::ELEM_W-1:0] o_new_re,
    output logic signed [hpr2_pkg::ELEM_W-1:0] o_new_im,
    output logic                               o_written,
    output logic                               o_saturated
);

    localparam int unsigned EW  = hpr2_pkg::ELEM_W;
    localparam int unsigned PW  = 2 * hpr2_pkg::VEC_W;
    localparam int unsigned SW  = PW + 1;
    localparam int unsigned MW  = SW + hpr2_pkg::VEC_W;
    localparam int unsigned AW  = MW + 1;
    localparam int unsigned TW  = AW - 16;
    localparam int unsigned FW  = TW + 2;
    localparam logic signed [FW-1:0] SAT_MAX = FW'(64'sh7FFF_FFFF);
    localparam logic signed [FW-1:0] SAT_MIN = FW'(-64'sh8000_0000);

    // stage 1: vector products
    logic signed [PW-1:0] r_s1_prod [8];
    logic signed [EW-1:0] r_s1_ap_re, r_s1_ap_im;
    logic                 r_s1_vld;
    // stage 2: p and q
    logic signed [SW-1:0] r_s2_pr, r_s2_pi, r_s2_qr, r_s2_qi;
    logic signed [EW-1:0] r_s2_ap_re, r_s2_ap_im;
    hpr2_pkg::t_tag       r_s2_tag;
    logic                 r_s2_vld;
    // stage 3: alpha products
    logic signed [MW-1:0] r_s3_m [8];
    logic signed [EW-1:0] r_s3_ap_re, r_s3_ap_im;
    hpr2_pkg::t_tag       r_s3_tag;
    logic                 r_s3_vld;
    // stage 4: truncated terms
    logic signed [TW-1:0] r_s4_t1r, r_s4_t1i, r_s4_t2r, r_s4_t2i;
    logic signed [EW-1:0] r_s4_ap_re, r_s4_ap_im;
    hpr2_pkg::t_tag       r_s4_tag;
    logic                 r_s4_vld;
    // output
    logic                       r_o_vld;
    logic [hpr2_pkg::IDX_W-1:0] r_o_idx;
    logic signed [EW-1:0]       r_o_re, r_o_im;
    logic                       r_o_wr, r_o_sat;

    logic signed [AW-1:0] w_a0, w_a1, w_a2, w_a3;
    logic signed [FW-1:0] w_sum_re, w_sum_im, w_old_im;
    logic signed [EW-1:0] w_re, w_im;
    logic                 w_sat_re, w_sat_im, w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_o_vld  <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod[0] <= PW'(i_x_col_re) * PW'(i_y_row_re);
        r_s1_prod[1] <= PW'(i_x_col_im) * PW'(i_y_row_im);
        r_s1_prod[2] <= PW'(i_x_col_im) * PW'(i_y_row_re);
        r_s1_prod[3] <= PW'(i_x_col_re) * PW'(i_y_row_im);
        r_s1_prod[4] <= PW'(i_y_col_re) * PW'(i_x_row_re);
        r_s1_prod[5] <= PW'(i_y_col_im) * PW'(i_x_row_im);
        r_s1_prod[6] <= PW'(i_y_col_im) * PW'(i_x_row_re);
        r_s1_prod[7] <= PW'(i_y_col_re) * PW'(i_x_row_im);
        r_s1_ap_re   <= i_ap_re;
        r_s1_ap_im   <= i_ap_im;
    end

    always_ff @(posedge i_clk) begin
        r_s2_pr    <= SW'(r_s1_prod[0]) + SW'(r_s1_prod[1]);
        r_s2_pi    <= SW'(r_s1_prod[2]) - SW'(r_s1_prod[3]);
        r_s2_qr    <= SW'(r_s1_prod[4]) + SW'(r_s1_prod[5]);
        r_s2_qi    <= SW'(r_s1_prod[6]) - SW'(r_s1_prod[7]);
        r_s2_ap_re <= r_s1_ap_re;
        r_s2_ap_im <= r_s1_ap_im;
        r_s2_tag   <= i_s1_tag;
    end

    always_ff @(posedge i_clk) begin
        r_s3_m[0]  <= MW'(i_cfg.alpha_re) * MW'(r_s2_pr);
        r_s3_m[1]  <= MW'(i_cfg.alpha_im) * MW'(r_s2_pi);
        r_s3_m[2]  <= MW'(i_cfg.alpha_re) * MW'(r_s2_pi);
        r_s3_m[3]  <= MW'(i_cfg.alpha_im) * MW'(r_s2_pr);
        r_s3_m[4]  <= MW'(i_cfg.alpha_re) * MW'(r_s2_qr);
        r_s3_m[5]  <= MW'(i_cfg.alpha_im) * MW'(r_s2_qi);
        r_s3_m[6]  <= MW'(i_cfg.alpha_re) * MW'(r_s2_qi);
        r_s3_m[7]  <= MW'(i_cfg.alpha_im) * MW'(r_s2_qr);
        r_s3_ap_re <= r_s2_ap_re;
        r_s3_ap_im <= r_s2_ap_im;
        r_s3_tag   <= r_s2_tag;
    end

    always_comb begin
        w_a0 = AW'(r_s3_m[0]) - AW'(r_s3_m[1]);
        w_a1 = AW'(r_s3_m[2]) + AW'(r_s3_m[3]);
        w_a2 = AW'(r_s3_m[4]) + AW'(r_s3_m[5]);
        w_a3 = AW'(r_s3_m[6]) - AW'(r_s3_m[7]);
    end

    // floor division by 2^16
    always_ff @(posedge i_clk) begin
        r_s4_t1r   <= TW'(w_a0 >>> 16);
        r_s4_t1i   <= TW'(w_a1 >>> 16);
        r_s4_t2r   <= TW'(w_a2 >>> 16);
        r_s4_t2i   <= TW'(w_a3 >>> 16);
        r_s4_ap_re <= r_s3_ap_re;
        r_s4_ap_im <= r_s3_ap_im;
        r_s4_tag   <= r_s3_tag;
    end

    always_comb begin
        w_old_im = r_s4_tag.diag ? '0 : FW'(r_s4_ap_im);
        w_sum_re = FW'(r_s4_ap_re) + FW'(r_s4_t1r) + FW'(r_s4_t2r);
        w_sum_im = w_old_im + FW'(r_s4_t1i) + FW'(r_s4_t2i);
        w_sat_re = (w_sum_re > SAT_MAX) || (w_sum_re < SAT_MIN);
        w_sat_im = (w_sum_im > SAT_MAX) || (w_sum_im < SAT_MIN);
        if (w_sum_re > SAT_MAX) begin
            w_re = EW'(SAT_MAX);
        end else if (w_sum_re < SAT_MIN) begin
            w_re = EW'(SAT_MIN);
        end else begin
            w_re = EW'(w_sum_re);
        end
        if (w_sum_im > SAT_MAX) begin
            w_im = EW'(SAT_MAX);
        end else if (w_sum_im < SAT_MIN) begin
            w_im = EW'(SAT_MIN);
        end else begin
            w_im = EW'(w_sum_im);
        end
        w_wr = r_s4_tag.in_tri && ((i_cfg.alpha_re != '0) || (i_cfg.alpha_im != '0));
    end

    always_ff @(posedge i_clk) begin
        r_o_idx <= r_s4_tag.idx;
        r_o_wr  <= w_wr;
        r_o_sat <= w_wr && (w_sat_re || w_sat_im);
        r_o_re  <= w_wr ? w_re : r_s4_ap_re;
        r_o_im  <= w_wr ? w_im : r_s4_ap_im;
    end

    assign o_valid        = r_o_vld;
    assign o_packed_index = r_o_idx;
    assign o_new_re       = r_o_re;
    assign o_new_im       = r_o_im;
    assign o_written      = r_o_wr;
    assign o_saturated    = r_o_sat;

endmodule

// ===== design/hermitian_packed_rank2_update_core.sv =====
// Top level of the Hermitian packed rank-2 update core.
// Depends on hpr2_pkg, hpr2_regs, hpr2_index and hpr2_mac.
//
// Usage:
//   Input channel: drive the element indices, the x and y vector elements
//   and the stored packed element, and raise start. The transfer happens at
//   each clock edge with start high and busy low; busy is always low, so a
//   new element may be given in every cycle.
//   Result channel: o_valid marks one cycle carrying o_packed_index,
//   o_new_re, o_new_im, o_written and o_saturated. There is no back
//   pressure; the receiver must take each result in its one cycle.
//   Results come out in order. Throughput is one element per cycle,
//   set by a five-stage pipeline (index and vector products, p/q sums,
//   alpha products, truncation, saturating add).
//   Configuration: APB, registers alpha_re, alpha_im, upper_mode and order
//   at byte addresses 0, 4, 8 and 12. Write them only while no element is
//   in flight.
//   Reset: synchronous, active low; clears the pipeline valid bits and sets
//   alpha to 0, upper_mode to 1 and order to 0.
module hermitian_packed_rank2_update_core #(
    parameter int unsigned MAX_ORDER = hpr2_pkg::MAX_ORDER
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpr2_pkg::ADDR_W-1:0]         paddr,
    input  logic [hpr2_pkg::DATA_W-1:0]         pwdata,
    output logic [hpr2_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [hpr2_pkg::POS_W-1:0]          i_col_pos,
    input  logic [hpr2_pkg::POS_W-1:0]          i_row_pos,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_x_col_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_x_col_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_y_col_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_y_col_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_x_row_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_x_row_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_y_row_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_y_row_im,
    input  logic signed [hpr2_pkg::ELEM_W-1:0]  i_ap_re,
    input  logic signed [hpr2_pkg::ELEM_W-1:0]  i_ap_im,
    output logic                                o_valid,
    output logic [hpr2_pkg::IDX_W-1:0]          o_packed_index,
    output logic signed [hpr2_pkg::ELEM_W-1:0]  o_new_re,
    output logic signed [hpr2_pkg::ELEM_W-1:0]  o_new_im,
    output logic                                o_written,
    output logic                                o_saturated
);

    hpr2_pkg::t_cfg w_cfg;
    hpr2_pkg::t_tag w_s1_tag;
    logic           w_take;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    hpr2_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hpr2_index #(
        .MAX_ORDER (MAX_ORDER)
    ) u_index (
        .i_clk     (i_clk),
        .i_cfg     (w_cfg),
        .i_col_pos (i_col_pos),
        .i_row_pos (i_row_pos),
        .o_tag     (w_s1_tag)
    );

    hpr2_mac u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_vld          (w_take),
        .i_x_col_re     (i_x_col_re),
        .i_x_col_im     (i_x_col_im),
        .i_y_col_re     (i_y_col_re),
        .i_y_col_im     (i_y_col_im),
        .i_x_row_re     (i_x_row_re),
        .i_x_row_im     (i_x_row_im),
        .i_y_row_re     (i_y_row_re),
        .i_y_row_im     (i_y_row_im),
        .i_ap_re        (i_ap_re),
        .i_ap_im        (i_ap_im),
        .i_s1_tag       (w_s1_tag),
        .o_valid        (o_valid),
        .o_packed_index (o_packed_index),
        .o_new_re       (o_new_re),
        .o_new_im       (o_new_im),
        .o_written      (o_written),
        .o_saturated    (o_saturated)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_take, 5))
        else $error("result without a transfer five cycles earlier");

    a_sat_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> o_written)
        else $error("saturation flagged on an element that was not updated");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_written) |->
            (o_new_re == $past(i_ap_re, 5)) && (o_new_im == $past(i_ap_im, 5)))
        else $error("unwritten element not passed through");

    a_write_needs_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_written) |-> ((w_cfg.alpha_re != '0) || (w_cfg.alpha_im != '0)))
        else $error("element updated with alpha zero");

endmodule

// ===== sim/hpr2_update_checker.sv =====
// Checker for the Hermitian packed rank-2 update core: mirrors the APB registers,
// predicts each element update and compares it with the result channel.
// Depends on hpr2_pkg.
`timescale 1ns / 100ps

module hpr2_update_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpr2_pkg::ADDR_W-1:0]         paddr,
    input  logic [hpr2_pkg::DATA_W-1:0]         pwdata,
    input  logic [hpr2_pkg::DATA_W-1:0]         prdata,
    input  logic                                pready,
    input  logic                                start,
    input  logic                                busy,
    input  logic [hpr2_pkg::POS_W-1:0]          i_col_pos,
    input  logic [hpr2_pkg::POS_W-1:0]          i_row_pos,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_x_col_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_x_col_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_y_col_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_y_col_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_x_row_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_x_row_im,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_y_row_re,
    input  logic signed [hpr2_pkg::VEC_W-1:0]   i_y_row_im,
    input  logic signed [hpr2_pkg::ELEM_W-1:0]  i_ap_re,
    input  logic signed [hpr2_pkg::ELEM_W-1:0]  i_ap_im,
    input  logic                                o_valid,
    input  logic [hpr2_pkg::IDX_W-1:0]          o_packed_index,
    input  logic signed [hpr2_pkg::ELEM_W-1:0]  o_new_re,
    input  logic signed [hpr2_pkg::ELEM_W-1:0]  o_new_im,
    input  logic                                o_written,
    input  logic                                o_saturated,
    output int unsigned                         mismatch_count = 0,
    output int unsigned                         pending_count = 0
);

    typedef struct {
        logic [hpr2_pkg::IDX_W-1:0]         idx;
        logic signed [hpr2_pkg::ELEM_W-1:0] re;
        logic signed [hpr2_pkg::ELEM_W-1:0] im;
        logic                               written;
        logic                               saturated;
    } t_update;

    hpr2_pkg::t_cfg cfg_mirror;
    t_update        expected_updates[$];

    function automatic logic [hpr2_pkg::ELEM_W-1:0] clip_q229(input longint v,
                                                               inout logic hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[hpr2_pkg::ELEM_W-1:0];
    endfunction

    // Update of the element on the input ports under the mirrored registers
    function automatic t_update predict_update();
        t_update r;
        longint ar, ai, n, tx, ty, idx;
        longint xcr, xci, ycr, yci, xrr, xri, yrr, yri, apr, api;
        longint pr, pi, qr, qi, t1r, t1i, t2r, t2i, oi;
        logic in_tri;
        logic hit;
        ar  = longint'($signed(cfg_mirror.alpha_re));
        ai  = longint'($signed(cfg_mirror.alpha_im));
        n   = (cfg_mirror.order > hpr2_pkg::MAX_ORDER) ? hpr2_pkg::MAX_ORDER
                                                       : cfg_mirror.order;
        tx  = i_col_pos;
        ty  = i_row_pos;
        xcr = i_x_col_re;
        xci = i_x_col_im;
        ycr = i_y_col_re;
        yci = i_y_col_im;
        xrr = i_x_row_re;
        xri = i_x_row_im;
        yrr = i_y_row_re;
        yri = i_y_row_im;
        apr = i_ap_re;
        api = i_ap_im;
        idx = 0;
        hit = 1'b0;
        r.re = i_ap_re;
        r.im = i_ap_im;
        r.written = 1'b0;
        if (cfg_mirror.upper_mode) begin
            in_tri = (ty < n) && (tx <= ty);
            if (in_tri) idx = (ty * (ty + 1)) / 2 + tx;
        end else begin
            in_tri = (tx < n) && (ty <= tx);
            if (in_tri) idx = (ty * (2 * n - ty + 1)) / 2 + (tx - ty);
        end
        r.idx = idx[hpr2_pkg::IDX_W-1:0];
        if (in_tri && (ar != 0 || ai != 0)) begin
            pr  = xcr * yrr + xci * yri;
            pi  = xci * yrr - xcr * yri;
            qr  = ycr * xrr + yci * xri;
            qi  = yci * xrr - ycr * xri;
            t1r = (ar * pr - ai * pi) >>> 16;
            t1i = (ar * pi + ai * pr) >>> 16;
            t2r = (ar * qr + ai * qi) >>> 16;
            t2i = (ar * qi - ai * qr) >>> 16;
            oi  = (tx == ty) ? 0 : api;
            r.re = clip_q229(apr + t1r + t2r, hit);
            r.im = clip_q229(oi + t1i + t2i, hit);
            r.written = 1'b1;
        end
        r.saturated = hit;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want_v,
                                   input longint got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_update                     want;
        logic [hpr2_pkg::DATA_W-1:0] reg_mask;
        logic [hpr2_pkg::DATA_W-1:0] reg_want;
        if (!i_rst_n) begin
            cfg_mirror = '0;
            cfg_mirror.upper_mode = 1'b1;
            expected_updates.delete();
        end else begin
            if (o_valid) begin
                if (expected_updates.size() == 0) begin
                    report_mismatch("unexpected result, packed_index", -1, o_packed_index);
                end else begin
                    want = expected_updates.pop_front();
                    if (o_packed_index !== want.idx)
                        report_mismatch("packed_index", want.idx, o_packed_index);
                    if (o_new_re !== want.re)
                        report_mismatch("new_re", want.re, o_new_re);
                    if (o_new_im !== want.im)
                        report_mismatch("new_im", want.im, o_new_im);
                    if (o_written !== want.written)
                        report_mismatch("written", want.written, o_written);
                    if (o_saturated !== want.saturated)
                        report_mismatch("saturated", want.saturated, o_saturated);
                end
            end
            if (start && !busy) expected_updates.push_back(predict_update());
            if (psel && penable && pready) begin
                case (hpr2_pkg::t_reg_sel'(paddr[3:2]))
                    hpr2_pkg::REG_ALPHA_RE: begin
                        reg_mask = 32'h0000_FFFF;
                        reg_want = {16'h0, cfg_mirror.alpha_re};
                    end
                    hpr2_pkg::REG_ALPHA_IM: begin
                        reg_mask = 32'h0000_FFFF;
                        reg_want = {16'h0, cfg_mirror.alpha_im};
                    end
                    hpr2_pkg::REG_UPPER_MODE: begin
                        reg_mask = 32'h0000_0001;
                        reg_want = {31'h0, cfg_mirror.upper_mode};
                    end
                    default: begin
                        reg_mask = 32'h0000_07FF;
                        reg_want = {21'h0, cfg_mirror.order};
                    end
                endcase
                if (pwrite) begin
                    case (hpr2_pkg::t_reg_sel'(paddr[3:2]))
                        hpr2_pkg::REG_ALPHA_RE:
                            cfg_mirror.alpha_re = pwdata[hpr2_pkg::VEC_W-1:0];
                        hpr2_pkg::REG_ALPHA_IM:
                            cfg_mirror.alpha_im = pwdata[hpr2_pkg::VEC_W-1:0];
                        hpr2_pkg::REG_UPPER_MODE:
                            cfg_mirror.upper_mode = pwdata[0];
                        default:
                            cfg_mirror.order = pwdata[hpr2_pkg::ORDER_W-1:0];
                    endcase
                end else if ((prdata & reg_mask) !== reg_want) begin
                    report_mismatch("register readback", reg_want, prdata & reg_mask);
                end
            end
        end
        pending_count = expected_updates.size();
    end

endmodule

// ===== sim/hermitian_packed_rank2_update_core_test.sv =====
// Testbench top for hermitian_packed_rank2_update_core: drives APB settings and
// element transfers with random gaps; hpr2_update_checker predicts and compares.
// Depends on hpr2_pkg, the core and hpr2_update_checker.
`timescale 1ns / 100ps

module hermitian_packed_rank2_update_core_test;

    localparam int LATENCY     = 5;
    localparam int STALL_LIMIT = 200;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [hpr2_pkg::ADDR_W-1:0]        paddr = '0;
    logic [hpr2_pkg::DATA_W-1:0]        pwdata = '0;
    logic [hpr2_pkg::DATA_W-1:0]        prdata;
    logic                               pready;
    logic                               start = 1'b0;
    logic                               busy;
    logic [hpr2_pkg::POS_W-1:0]         i_col_pos = '0;
    logic [hpr2_pkg::POS_W-1:0]         i_row_pos = '0;
    logic signed [hpr2_pkg::VEC_W-1:0]  i_x_col_re = '0;
    logic signed [hpr2_pkg::VEC_W-1:0]  i_x_col_im = '0;
    logic signed [hpr2_pkg::VEC_W-1:0]  i_y_col_re = '0;
    logic signed [hpr2_pkg::VEC_W-1:0]  i_y_col_im = '0;
    logic signed [hpr2_pkg::VEC_W-1:0]  i_x_row_re = '0;
    logic signed [hpr2_pkg::VEC_W-1:0]  i_x_row_im = '0;
    logic signed [hpr2_pkg::VEC_W-1:0]  i_y_row_re = '0;
    logic signed [hpr2_pkg::VEC_W-1:0]  i_y_row_im = '0;
    logic signed [hpr2_pkg::ELEM_W-1:0] i_ap_re = '0;
    logic signed [hpr2_pkg::ELEM_W-1:0] i_ap_im = '0;
    logic                               o_valid;
    logic [hpr2_pkg::IDX_W-1:0]         o_packed_index;
    logic signed [hpr2_pkg::ELEM_W-1:0] o_new_re;
    logic signed [hpr2_pkg::ELEM_W-1:0] o_new_im;
    logic                               o_written;
    logic                               o_saturated;
    int unsigned                        mismatch_count;
    int unsigned                        pending_count;

    int unsigned quiet_cycles = 0;
    int unsigned span_n = 0;
    bit          span_upper = 1'b1;
    bit          no_gaps = 1'b0;

    hermitian_packed_rank2_update_core i_dut (.*);

    hpr2_update_checker u_checker (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_access(input bit wr, input hpr2_pkg::t_reg_sel sel,
                              input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] a_re, input logic [15:0] a_im,
                             input bit upper, input logic [10:0] n);
        apb_access(1'b1, hpr2_pkg::REG_ALPHA_RE, {{16{a_re[15]}}, a_re});
        apb_access(1'b1, hpr2_pkg::REG_ALPHA_IM, {{16{a_im[15]}}, a_im});
        apb_access(1'b1, hpr2_pkg::REG_UPPER_MODE, {31'h0, upper});
        apb_access(1'b1, hpr2_pkg::REG_ORDER, {21'h0, n});
        apb_access(1'b0, hpr2_pkg::REG_ALPHA_RE, '0);
        apb_access(1'b0, hpr2_pkg::REG_ALPHA_IM, '0);
        apb_access(1'b0, hpr2_pkg::REG_UPPER_MODE, '0);
        apb_access(1'b0, hpr2_pkg::REG_ORDER, '0);
        span_upper = upper;
        span_n = (n > hpr2_pkg::MAX_ORDER) ? hpr2_pkg::MAX_ORDER : n;
    endtask

    task automatic send_element(input logic [9:0] col, input logic [9:0] row,
                                input logic [15:0] xcr, input logic [15:0] xci,
                                input logic [15:0] ycr, input logic [15:0] yci,
                                input logic [15:0] xrr, input logic [15:0] xri,
                                input logic [15:0] yrr, input logic [15:0] yri,
                                input logic [31:0] apr, input logic [31:0] api);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        i_col_pos  <= col;
        i_row_pos  <= row;
        i_x_col_re <= xcr;
        i_x_col_im <= xci;
        i_y_col_re <= ycr;
        i_y_col_im <= yci;
        i_x_row_re <= xrr;
        i_x_row_im <= xri;
        i_y_row_re <= yrr;
        i_y_row_im <= yri;
        i_ap_re    <= apr;
        i_ap_im    <= api;
        start      <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fill(input logic [9:0] col, input logic [9:0] row,
                             input logic [15:0] xv, input logic [15:0] yv,
                             input logic [31:0] apr, input logic [31:0] api);
        send_element(col, row, xv, xv, yv, yv, xv, xv, yv, yv, apr, api);
    endtask

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_elem();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'h7F00_0000 + $urandom_range(0, 32'h00FF_FFFF);
            4:       return 32'h8000_0000 + $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [10:0] pick_order();
        case ($urandom_range(0, 8))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2;
            3:       return 11'($urandom_range(3, 64));
            4:       return 11'd1023;
            5:       return 11'd1024;
            6:       return 11'd2047;
            7:       return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(0, 1024));
        endcase
    endfunction

    // Mostly elements of the stored triangle, some diagonal, some outside
    task automatic send_random();
        int unsigned hi, lo, kind;
        logic [9:0]  col, row;
        kind = $urandom_range(0, 9);
        hi = 0;
        lo = 0;
        if (span_n == 0 || kind == 9) begin
            hi = $urandom_range(0, 1023);
            lo = $urandom_range(0, 1023);
        end else if (kind <= 4) begin
            hi = $urandom_range(0, span_n - 1);
            lo = $urandom_range(0, hi);
        end else if (kind <= 6) begin
            hi = $urandom_range(0, span_n - 1);
            lo = hi;
        end else if (span_n < hpr2_pkg::MAX_ORDER && kind == 7) begin
            hi = $urandom_range(span_n, 1023);
            lo = $urandom_range(0, 1023);
        end else begin
            hi = $urandom_range(0, 1022);
            lo = $urandom_range(hi + 1, 1023);
        end
        col = span_upper ? lo[9:0] : hi[9:0];
        row = span_upper ? hi[9:0] : lo[9:0];
        send_element(col, row, pick_q15(), pick_q15(), pick_q15(), pick_q15(),
                     pick_q15(), pick_q15(), pick_q15(), pick_q15(),
                     pick_elem(), pick_elem());
    endtask

    task automatic finish_burst();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: order 0, every element is outside
        span_n = 0;
        span_upper = 1'b1;
        repeat (4) send_random();
        finish_burst();

        configure(16'h8000, 16'h8000, 1'b1, 11'd1024);
        send_fill(10'd0, 10'd0, 16'h7FFF, 16'h8000, 32'h1234_5678, 32'h7FFF_FFFF);
        send_fill(10'd1023, 10'd1023, 16'h8000, 16'h7FFF, 32'h8000_0000, 32'h8000_0000);
        send_fill(10'd0, 10'd1023, 16'h0001, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        send_fill(10'd5, 10'd3, 16'h7FFF, 16'h7FFF, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_fill(10'd2, 10'd7, 16'h8000, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_fill(10'd6, 10'd9, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_fill(10'd3, 10'd4, 16'h0000, 16'h0000, 32'h5555_5555, 32'hAAAA_AAAA);
        finish_burst();

        configure(16'h7FFF, 16'h7FFF, 1'b0, 11'd1024);
        send_fill(10'd0, 10'd0, 16'h8000, 16'h8000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_fill(10'd1023, 10'd1023, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_fill(10'd1023, 10'd0, 16'h7FFF, 16'h8000, 32'h8000_0000, 32'h8000_0000);
        send_fill(10'd3, 10'd5, 16'h1234, 16'hFEDC, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        send_fill(10'd9, 10'd2, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        finish_burst();

        // order above the maximum is taken as the maximum
        configure(16'h0001, 16'hFFFF, 1'b1, 11'd2047);
        send_fill(10'd1023, 10'd1023, 16'h7FFF, 16'h8000, 32'h0000_0000, 32'h4000_0000);
        send_fill(10'd1023, 10'd0, 16'h7FFF, 16'h7FFF, 32'h0000_0001, 32'h0000_0002);
        send_fill(10'd0, 10'd1023, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        finish_burst();

        // zero alpha passes the element through but keeps its position
        configure(16'h0000, 16'h0000, 1'b0, 11'd5);
        send_fill(10'd4, 10'd2, 16'h7FFF, 16'h8000, 32'h1111_1111, 32'h2222_2222);
        send_fill(10'd4, 10'd4, 16'h8000, 16'h8000, 32'h3333_3333, 32'h4444_4444);
        send_fill(10'd5, 10'd5, 16'h7FFF, 16'h7FFF, 32'h5555_5555, 32'h6666_6666);
        finish_burst();

        for (int burst = 0; burst < 8; burst++) begin
            configure(pick_q15(), pick_q15(), 1'($urandom_range(0, 1)), pick_order());
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (47) send_random();
            finish_burst();
        end

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/hpr2_pkg.sv
design/hpr2_regs.sv
design/hpr2_index.sv
design/hpr2_mac.sv
design/hermitian_packed_rank2_update_core.sv
sim/hpr2_update_checker.sv
sim/hermitian_packed_rank2_update_core_test.sv
